>>> src/drum_pattern_step_sequencer_top_macros.svh
// Assertion macros shared by the sequencer checker.
`ifndef DRUM_PATTERN_STEP_SEQUENCER_TOP_MACROS_SVH
`define DRUM_PATTERN_STEP_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DPSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define DPSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/dpss_pkg.sv
// Package with the shared types and constants of the drum step sequencer.
`timescale 1ns / 1ps

package dpss_pkg;

	// Item operation codes carried in the mode field.
	typedef enum logic [1:0] {
		MODE_CELL    = 2'd0,
		MODE_SEQ     = 2'd1,
		MODE_START   = 2'd2,
		MODE_ADVANCE = 2'd3
	} mode_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_STEP_TIME     = 2'd0;
	localparam logic [1:0] REG_SEQ_LENGTH    = 2'd1;
	localparam logic [1:0] REG_PATTERN_COUNT = 2'd2;

	// Configuration reset values.
	localparam logic [15:0] STEP_TIME_RESET     = 16'd125;
	localparam logic [4:0]  SEQ_LENGTH_RESET    = 5'd1;
	localparam logic [2:0]  PATTERN_COUNT_RESET = 3'd1;

	// Width of one pattern cell.
	localparam int CELL_BITS = 8;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_WALK,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic reduce;
		logic step;
		logic finish;
		logic emit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic adv_req;
		logic reduced;
		logic hit;
		logic at_limit;
	} dp_status_t;

endpackage

>>> src/dpss_ctrl.sv
// Controller state machine of the drum step sequencer.
`timescale 1ns / 1ps

module dpss_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  dpss_pkg::dp_status_t   status,
	output dpss_pkg::ctrl_cmd_t    cmd
);

	dpss_pkg::state_t state_q;
	dpss_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid flag: set when a result is loaded, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dpss_pkg::ST_IDLE: begin
				if (in_valid && status.adv_req) begin
					state_d = dpss_pkg::ST_REDUCE;
				end
			end
			dpss_pkg::ST_REDUCE: begin
				if (status.reduced) begin
					state_d = dpss_pkg::ST_WALK;
				end
			end
			dpss_pkg::ST_WALK: begin
				if (status.hit || status.at_limit) begin
					state_d = dpss_pkg::ST_DONE;
				end
			end
			dpss_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = dpss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dpss_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands and input handshake.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			dpss_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			dpss_pkg::ST_REDUCE: begin
				cmd.reduce = !status.reduced;
			end
			dpss_pkg::ST_WALK: begin
				if (status.hit || status.at_limit) begin
					cmd.finish = 1'b1;
				end else begin
					cmd.step = 1'b1;
				end
			end
			dpss_pkg::ST_DONE: begin
				cmd.emit = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> src/dpss_datapath.sv
// Datapath of the drum step sequencer: pattern memory, beat order, walkers and result.
`timescale 1ns / 1ps

module dpss_datapath #(
	parameter int LIMBS    = 3,
	parameter int STEPS    = 16,
	parameter int PATTERNS = 4,
	parameter int BEATS    = 16,
	parameter int POS_BITS = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_wdata,
	input  logic [1:0]             mode,
	input  logic [1:0]             limb,
	input  logic [1:0]             pattern_sel,
	input  logic [3:0]             step,
	input  logic                   hit,
	input  logic [2:0]             position,
	input  logic [7:0]             velocity,
	input  logic [3:0]             beat,
	input  logic [31:0]            start_time,
	input  dpss_pkg::ctrl_cmd_t    cmd,
	output dpss_pkg::dp_status_t   status,
	output logic [1:0]             out_limb,
	output logic [31:0]            hit_time,
	output logic [2:0]             hit_position,
	output logic [3:0]             hit_velocity,
	output logic                   found
);

	localparam int LIMB_W    = (LIMBS > 1) ? $clog2(LIMBS) : 1;
	localparam int PAT_W     = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
	localparam int SP_W      = $clog2(STEPS);
	localparam int BP_W      = (BEATS > 1) ? $clog2(BEATS) : 1;
	localparam int LEN_W     = $clog2(BEATS + 1);
	localparam int DEPTH     = LIMBS * PATTERNS * STEPS;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int N_W       = $clog2(BEATS * STEPS + 1);
	localparam int CB        = dpss_pkg::CELL_BITS;
	localparam int VEL_SHIFT = 1 + POS_BITS;
	localparam int VEL_MAX   = (1 << (CB - VEL_SHIFT)) - 1;
	localparam int POS_MASK  = (1 << POS_BITS) - 1;

	// Configuration registers.
	logic [15:0] step_time_q;
	logic [4:0]  seq_length_q;
	logic [2:0]  pattern_count_q;

	// Pattern memory with one valid bit per cell; a cell never written never counts as a hit.
	logic [CB-1:0]    pattern_mem_q [DEPTH];
	logic [DEPTH-1:0] cell_vld_q;
	logic [CB-1:0]    rd_cell_s1;
	logic             rd_vld_s1;

	// Beat order and per-limb walker state.
	logic [PAT_W-1:0] beat_order_q [BEATS];
	logic [SP_W-1:0]  step_ptr_q   [LIMBS];
	logic [LIMBS-1:0] fresh_q;
	logic [BP_W-1:0]  beat_ptr_q   [LIMBS];
	logic [31:0]      next_time_q  [LIMBS];

	// Active walk.
	logic [LIMB_W-1:0] limb_q;
	logic [SP_W-1:0]   sp_w_q;
	logic              fresh_w_q;
	logic [BP_W-1:0]   bp_w_q;
	logic [BP_W-1:0]   bp_m_q;
	logic [31:0]       t_w_q;
	logic [N_W-1:0]    n_q;
	logic [N_W-1:0]    limit_q;
	logic              chk_vld_q;
	logic              end_found_q;
	logic [CB-1:0]     end_cell_q;

	// Result register.
	logic [1:0]  out_limb_q;
	logic [31:0] hit_time_q;
	logic [2:0]  hit_position_q;
	logic [3:0]  hit_velocity_q;
	logic        out_found_q;

	// Decoded item.
	dpss_pkg::mode_t   in_mode;
	logic              limb_ok;
	logic [LIMB_W-1:0] in_limb_idx;
	logic              cell_we;
	logic              seq_we;
	logic              start_we;
	logic              adv_load;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        vel_sat;
	logic [CB-1:0]     new_cell;
	logic [PAT_W-1:0]  seq_val;
	int                pat_lim;

	// Walk step.
	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  b1;
	logic [SP_W-1:0]   sp_n;
	logic [BP_W-1:0]   bp_n;
	logic [BP_W-1:0]   bpm_n;
	logic [ADDR_W-1:0] rd_addr;
	logic              bp_reduced;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q     <= dpss_pkg::STEP_TIME_RESET;
			seq_length_q    <= dpss_pkg::SEQ_LENGTH_RESET;
			pattern_count_q <= dpss_pkg::PATTERN_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dpss_pkg::REG_STEP_TIME:     step_time_q     <= cfg_wdata;
				dpss_pkg::REG_SEQ_LENGTH:    seq_length_q    <= cfg_wdata[4:0];
				dpss_pkg::REG_PATTERN_COUNT: pattern_count_q <= cfg_wdata[2:0];
				default: begin
				end
			endcase
		end
	end

	// Sequence length clamped to one through the beat count.
	always_comb begin
		if (seq_length_q == 5'd0) begin
			len = LEN_W'(1);
		end else if (int'(seq_length_q) > BEATS) begin
			len = LEN_W'(BEATS);
		end else begin
			len = LEN_W'(seq_length_q);
		end
	end

	// Item decode.
	always_comb begin
		in_mode     = dpss_pkg::mode_t'(mode);
		limb_ok     = int'(limb) < LIMBS;
		in_limb_idx = LIMB_W'(limb);
		cell_we     = 1'b0;
		seq_we      = 1'b0;
		start_we    = 1'b0;
		adv_load    = 1'b0;
		case (in_mode)
			dpss_pkg::MODE_CELL: begin
				cell_we = cmd.accept && limb_ok && (int'(pattern_sel) < PATTERNS)
					&& (int'(step) < STEPS);
			end
			dpss_pkg::MODE_SEQ: begin
				seq_we = cmd.accept && (int'(beat) < BEATS);
			end
			dpss_pkg::MODE_START: begin
				start_we = cmd.accept;
			end
			dpss_pkg::MODE_ADVANCE: begin
				adv_load = cmd.accept && limb_ok;
			end
			default: begin
			end
		endcase
	end

	// Cell value: velocity saturated to what the cell can hold.
	always_comb begin
		wr_addr = ADDR_W'((int'(limb) * PATTERNS + int'(pattern_sel)) * STEPS + int'(step));
		vel_sat = (int'(velocity) > VEL_MAX) ? 8'(VEL_MAX) : velocity;
		if (hit) begin
			new_cell = CB'(1) | ((CB'(position) & CB'(POS_MASK)) << 1)
				| (CB'(vel_sat) << VEL_SHIFT);
		end else begin
			new_cell = '0;
		end
	end

	// Beat order entry: ids at or above the pattern count store zero.
	always_comb begin
		pat_lim = (int'(pattern_count_q) < PATTERNS) ? int'(pattern_count_q) : PATTERNS;
		seq_val = (int'(pattern_sel) < pat_lim) ? PAT_W'(pattern_sel) : '0;
	end

	// Next step of the walk, wrapping into the next beat at a pattern end.
	always_comb begin
		sp_n  = sp_w_q;
		bp_n  = bp_w_q;
		bpm_n = bp_m_q;
		b1    = LEN_W'(bp_m_q) + LEN_W'(1);
		if (fresh_w_q) begin
			sp_n = '0;
		end else if (sp_w_q == SP_W'(STEPS - 1)) begin
			sp_n  = '0;
			bpm_n = (b1 == len) ? '0 : BP_W'(b1);
			bp_n  = bpm_n;
		end else begin
			sp_n = sp_w_q + SP_W'(1);
		end
		rd_addr = ADDR_W'((int'(limb_q) * PATTERNS + int'(beat_order_q[bp_n])) * STEPS
			+ int'(sp_n));
	end

	assign bp_reduced = LEN_W'(bp_m_q) < len;

	// Status to the controller.
	always_comb begin
		status.adv_req  = (in_mode == dpss_pkg::MODE_ADVANCE) && limb_ok;
		status.reduced  = bp_reduced;
		status.hit      = chk_vld_q && rd_vld_s1 && rd_cell_s1[0];
		status.at_limit = chk_vld_q && (n_q == limit_q);
	end

	// Pattern memory write port.
	always_ff @(posedge clk) begin
		if (cell_we) begin
			pattern_mem_q[wr_addr] <= new_cell;
		end
	end

	// Pattern memory read port, registered.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rd_cell_s1 <= pattern_mem_q[rd_addr];
		end
	end

	// Cell valid bits and their registered read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (cell_we) begin
				cell_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.step) begin
				rd_vld_s1 <= cell_vld_q[rd_addr];
			end
		end
	end

	// Beat order table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BEATS; i++) begin
				beat_order_q[i] <= '0;
			end
		end else if (seq_we) begin
			beat_order_q[BP_W'(beat)] <= seq_val;
		end
	end

	// Per-limb pointers and next-hit times; a walk commits only when it finds a hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= '1;
			for (int i = 0; i < LIMBS; i++) begin
				step_ptr_q[i]  <= '0;
				beat_ptr_q[i]  <= '0;
				next_time_q[i] <= '0;
			end
		end else if (start_we) begin
			for (int i = 0; i < LIMBS; i++) begin
				next_time_q[i] <= start_time;
			end
		end else if (cmd.emit && end_found_q) begin
			step_ptr_q[limb_q]  <= sp_w_q;
			fresh_q[limb_q]     <= 1'b0;
			beat_ptr_q[limb_q]  <= bp_w_q;
			next_time_q[limb_q] <= t_w_q;
		end
	end

	// Walker: loaded on an advance, reduced into the sequence, then stepped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limb_q    <= '0;
			sp_w_q    <= '0;
			fresh_w_q <= 1'b1;
			bp_w_q    <= '0;
			bp_m_q    <= '0;
			t_w_q     <= '0;
			n_q       <= '0;
			limit_q   <= '0;
		end else if (adv_load) begin
			limb_q    <= in_limb_idx;
			sp_w_q    <= step_ptr_q[in_limb_idx];
			fresh_w_q <= fresh_q[in_limb_idx];
			bp_w_q    <= beat_ptr_q[in_limb_idx];
			bp_m_q    <= beat_ptr_q[in_limb_idx];
			t_w_q     <= next_time_q[in_limb_idx];
			n_q       <= '0;
			limit_q   <= N_W'(int'(len) * STEPS);
		end else if (cmd.reduce && !bp_reduced) begin
			bp_m_q <= BP_W'(LEN_W'(bp_m_q) - len);
		end else if (cmd.step) begin
			sp_w_q    <= sp_n;
			fresh_w_q <= 1'b0;
			bp_w_q    <= bp_n;
			bp_m_q    <= bpm_n;
			t_w_q     <= t_w_q + 32'(step_time_q);
			n_q       <= n_q + N_W'(1);
		end
	end

	// Read data lines up with the walker in the cycle after a step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_vld_q <= 1'b0;
		end else begin
			chk_vld_q <= cmd.step;
		end
	end

	// End of walk: keep the outcome and the found cell.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			end_found_q <= status.hit;
			end_cell_q  <= rd_cell_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_limb_q  <= 2'(limb_q);
			out_found_q <= end_found_q;
			if (end_found_q) begin
				hit_time_q     <= t_w_q;
				hit_position_q <= 3'((end_cell_q >> 1) & CB'(POS_MASK));
				hit_velocity_q <= 4'(end_cell_q >> VEL_SHIFT);
			end else begin
				hit_time_q     <= next_time_q[limb_q];
				hit_position_q <= '0;
				hit_velocity_q <= '0;
			end
		end
	end

	assign out_limb     = out_limb_q;
	assign hit_time     = hit_time_q;
	assign hit_position = hit_position_q;
	assign hit_velocity = hit_velocity_q;
	assign found        = out_found_q;

endmodule

>>> src/drum_pattern_step_sequencer_top.sv
// Top level of the per-limb drum step sequencer.
//
//  Channel  Direction  Handshake            Payload
//  cfg      in         cfg_we               cfg_index, cfg_wdata
//  in       in         in_valid / in_ready  mode, limb, pattern_sel, step, hit, position,
//                                           velocity, beat, start_time
//  out      out        out_valid / out_ready out_limb, hit_time, hit_position,
//                                           hit_velocity, found
//
// Cell, beat-order and start-time items complete on acceptance; the input stays open.
// An advance passes through REDUCE, WALK and DONE: R subtractions when the stored beat
// pointer lies beyond a shortened sequence length, then S steps walked (one per cycle
// through the pattern memory's registered read port, at most clamped seq_length * STEPS).
// Reset clears control state and valid bits, not cell data; there is no clearing pass.
// A waiting result stalls only the end of the next advance; other items pass freely.
`timescale 1ns / 1ps

module drum_pattern_step_sequencer_top #(
	parameter int LIMBS    = 3,
	parameter int STEPS    = 16,
	parameter int PATTERNS = 4,
	parameter int BEATS    = 16,
	parameter int POS_BITS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [1:0]  limb,
	input  logic [1:0]  pattern_sel,
	input  logic [3:0]  step,
	input  logic        hit,
	input  logic [2:0]  position,
	input  logic [7:0]  velocity,
	input  logic [3:0]  beat,
	input  logic [31:0] start_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_limb,
	output logic [31:0] hit_time,
	output logic [2:0]  hit_position,
	output logic [3:0]  hit_velocity,
	output logic        found
);

	dpss_pkg::ctrl_cmd_t  cmd;
	dpss_pkg::dp_status_t status;

	// Sequencing of each item.
	dpss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Storage, walk and result.
	dpss_datapath #(
		.LIMBS    (LIMBS),
		.STEPS    (STEPS),
		.PATTERNS (PATTERNS),
		.BEATS    (BEATS),
		.POS_BITS (POS_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mode         (mode),
		.limb         (limb),
		.pattern_sel  (pattern_sel),
		.step         (step),
		.hit          (hit),
		.position     (position),
		.velocity     (velocity),
		.beat         (beat),
		.start_time   (start_time),
		.cmd          (cmd),
		.status       (status),
		.out_limb     (out_limb),
		.hit_time     (hit_time),
		.hit_position (hit_position),
		.hit_velocity (hit_velocity),
		.found        (found)
	);

endmodule

>>> src/dpss_checker.sv
// Port-level checker for the drum step sequencer and its bind to the top level.
`timescale 1ns / 1ps
`include "drum_pattern_step_sequencer_top_macros.svh"

module dpss_checker #(
	parameter int LIMBS = 3
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  mode,
	input logic [1:0]  limb,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_limb,
	input logic [31:0] hit_time,
	input logic [2:0]  hit_position,
	input logic        found
);

	// An accepted advance on a real limb keeps the input closed while it walks.
	`DPSS_ASSERT_NEXT(a_advance_busy, in_valid && in_ready && (mode == dpss_pkg::MODE_ADVANCE) && (int'(limb) < LIMBS), !in_ready, "advance item did not close the input")

	// Items other than an advance leave the input open for the next item.
	`DPSS_ASSERT_NEXT(a_write_one_cycle, in_valid && in_ready && (mode != dpss_pkg::MODE_ADVANCE), in_ready, "non-advance item held the input")

	// A new result only appears at the end of a walk, while the input is closed.
	`DPSS_ASSERT_NOW(a_result_after_walk, $rose(out_valid), $past(!in_ready), "result appeared without a walk")

	// A stalled result holds.
	`DPSS_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(hit_time) && $stable(out_limb) && $stable(found) && $stable(hit_position), "stalled result changed")

endmodule

bind drum_pattern_step_sequencer_top dpss_checker #(.LIMBS(LIMBS)) u_dpss_checker (.*);
